// ===== rtl/core/suh_pkg.sv =====
// shared types and constants of the socks5 udp header parser
package suh_pkg;

  localparam int LEN_W = 16;

  // byte roles
  localparam logic [2:0] ROLE_RSV  = 3'd0;
  localparam logic [2:0] ROLE_TYPE = 3'd1;
  localparam logic [2:0] ROLE_LEN  = 3'd2;
  localparam logic [2:0] ROLE_ADDR = 3'd3;
  localparam logic [2:0] ROLE_PORT = 3'd4;
  localparam logic [2:0] ROLE_PAY  = 3'd5;

  // address kinds
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_V4   = 2'd1;
  localparam logic [1:0] KIND_DOM  = 2'd2;
  localparam logic [1:0] KIND_V6   = 2'd3;

  // address type codes on the wire
  localparam logic [7:0] ATYP_V4  = 8'h01;
  localparam logic [7:0] ATYP_DOM = 8'h03;
  localparam logic [7:0] ATYP_V6  = 8'h04;

  // verdicts
  localparam logic [2:0] VERDICT_OK        = 3'd0;
  localparam logic [2:0] VERDICT_SHORT     = 3'd1;
  localparam logic [2:0] VERDICT_RSV_BAD   = 3'd2;
  localparam logic [2:0] VERDICT_TYPE_BAD  = 3'd3;
  localparam logic [2:0] VERDICT_ZERO_NAME = 3'd4;

  // header lengths
  localparam logic [LEN_W-1:0] MIN_LEN      = LEN_W'(4);
  localparam logic [LEN_W-1:0] HDR_V4       = LEN_W'(10);
  localparam logic [LEN_W-1:0] HDR_V6       = LEN_W'(22);
  localparam logic [LEN_W-1:0] HDR_DOM_BASE = LEN_W'(7);

  // queue between front and back
  localparam int FIFO_DEPTH = 2;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic [7:0]       data;
    logic [2:0]       role;
    logic [7:0]       offset;
    logic [1:0]       kind;
    logic             eop;
    logic [LEN_W-1:0] len;
    logic             rsv_bad;
    logic             type_bad;
    logic [7:0]       name_len;
  } item_t;

endpackage

// ===== rtl/core/suh_front.sv =====
// front end: tracks byte position and header state, tags each byte
module suh_front #(
  parameter int MAX_DATAGRAM_BYTES = 65535
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [7:0]    data_byte_i,
  input  logic          end_of_packet_i,
  output suh_pkg::item_t item_o
);
  import suh_pkg::*;

  localparam int POS_W = $clog2(MAX_DATAGRAM_BYTES + 1);
  localparam int EXT_W = LEN_W + 1;
  localparam logic [POS_W-1:0] POS_MAX  = POS_W'(MAX_DATAGRAM_BYTES);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_DATAGRAM_BYTES - 1);

  logic [POS_W-1:0] pos_q, pos_d;
  logic [1:0]       kind_q, kind_d;
  logic [7:0]       name_len_q, name_len_d;
  logic             rsv_bad_q, rsv_bad_d;
  logic             type_bad_q, type_bad_d;

  logic [POS_W-1:0] p;
  logic [POS_W-1:0] addr_end;
  logic [EXT_W-1:0] p_ext;
  logic [EXT_W-1:0] nl_ext;
  logic [2:0]       role;
  logic [7:0]       offset;
  logic [1:0]       kind_upd;
  logic [7:0]       name_len_upd;
  logic             rsv_bad_upd;
  logic             type_bad_upd;

  // position saturates one below the limit for tagging
  assign p      = (pos_q == POS_MAX) ? POS_LAST : pos_q;
  assign p_ext  = EXT_W'(p);
  assign nl_ext = EXT_W'(name_len_q);

  always_comb begin
    role         = ROLE_PAY;
    offset       = 8'd0;
    kind_upd     = kind_q;
    name_len_upd = name_len_q;
    rsv_bad_upd  = rsv_bad_q;
    type_bad_upd = type_bad_q;
    addr_end     = (kind_q == KIND_V4) ? POS_W'(8) : POS_W'(20);
    if (p < POS_W'(3)) begin
      role = ROLE_RSV;
      if (data_byte_i != 8'd0) begin
        rsv_bad_upd = 1'b1;
      end
    end else if (p == POS_W'(3)) begin
      role = ROLE_TYPE;
      case (data_byte_i)
        ATYP_V4:  kind_upd = KIND_V4;
        ATYP_DOM: kind_upd = KIND_DOM;
        ATYP_V6:  kind_upd = KIND_V6;
        default: begin
          kind_upd     = KIND_NONE;
          type_bad_upd = 1'b1;
        end
      endcase
    end else if (kind_q == KIND_V4 || kind_q == KIND_V6) begin
      if (p < addr_end) begin
        role   = ROLE_ADDR;
        offset = 8'(p - POS_W'(4));
      end else if (p < addr_end + POS_W'(2)) begin
        role   = ROLE_PORT;
        offset = 8'(p - addr_end);
      end
    end else if (kind_q == KIND_DOM) begin
      if (p == POS_W'(4)) begin
        role         = ROLE_LEN;
        name_len_upd = data_byte_i;
      end else if (p_ext < nl_ext + EXT_W'(5)) begin
        role   = ROLE_ADDR;
        offset = 8'(p_ext - EXT_W'(5));
      end else if (p_ext < nl_ext + EXT_W'(7)) begin
        role   = ROLE_PORT;
        offset = 8'(p_ext - EXT_W'(5) - nl_ext);
      end
    end
  end

  always_comb begin
    item_o.data     = data_byte_i;
    item_o.role     = role;
    item_o.offset   = offset;
    item_o.kind     = kind_upd;
    item_o.eop      = end_of_packet_i;
    item_o.len      = LEN_W'(p) + LEN_W'(1);
    item_o.rsv_bad  = rsv_bad_upd;
    item_o.type_bad = type_bad_upd;
    item_o.name_len = name_len_upd;
  end

  always_comb begin
    pos_d      = pos_q;
    kind_d     = kind_q;
    name_len_d = name_len_q;
    rsv_bad_d  = rsv_bad_q;
    type_bad_d = type_bad_q;
    if (valid_i) begin
      if (end_of_packet_i) begin
        pos_d      = '0;
        kind_d     = KIND_NONE;
        name_len_d = 8'd0;
        rsv_bad_d  = 1'b0;
        type_bad_d = 1'b0;
      end else begin
        if (pos_q != POS_MAX) begin
          pos_d = pos_q + POS_W'(1);
        end
        kind_d     = kind_upd;
        name_len_d = name_len_upd;
        rsv_bad_d  = rsv_bad_upd;
        type_bad_d = type_bad_upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      kind_q     <= KIND_NONE;
      name_len_q <= 8'd0;
      rsv_bad_q  <= 1'b0;
      type_bad_q <= 1'b0;
    end else begin
      pos_q      <= pos_d;
      kind_q     <= kind_d;
      name_len_q <= name_len_d;
      rsv_bad_q  <= rsv_bad_d;
      type_bad_q <= type_bad_d;
    end
  end

`ifndef SYNTHESIS
  a_eop_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && end_of_packet_i) |=> (pos_q == '0 && kind_q == KIND_NONE))
    else $error("state not cleared after final byte");

  a_kind_after_type: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q <= POS_W'(3)) |-> (kind_q == KIND_NONE && name_len_q == 8'd0))
    else $error("address kind known before type byte");

  a_type_bad_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    type_bad_q |-> (kind_q == KIND_NONE))
    else $error("bad type flagged with a known kind");
`endif

endmodule

// ===== rtl/core/suh_fifo.sv =====
// short queue of tagged bytes between front and back
module suh_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  suh_pkg::item_t wdata_i,
  input  logic           pop_i,
  output suh_pkg::item_t rdata_o,
  output logic           full_o,
  output logic           empty_o
);
  import suh_pkg::*;

  item_t            mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [PTR_W:0]   count_q;

  assign full_o  = (count_q == (PTR_W+1)'(FIFO_DEPTH));
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + (PTR_W+1)'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - (PTR_W+1)'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("push into full queue");
`endif

endmodule

// ===== rtl/core/suh_back.sv =====
// back end: verdict and payload length, registered result stage
module suh_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  suh_pkg::item_t item_i,
  input  logic           item_valid_i,
  output logic           item_take_o,
  input  logic           pop_i,
  output logic           empty_o,
  output logic [7:0]     byte_out_o,
  output logic [2:0]     byte_role_o,
  output logic [7:0]     field_offset_o,
  output logic [1:0]     address_kind_o,
  output logic           packet_done_o,
  output logic [2:0]     verdict_o,
  output logic [15:0]    payload_bytes_o
);
  import suh_pkg::*;

  logic             valid_q;
  logic [7:0]       byte_q;
  logic [2:0]       role_q;
  logic [7:0]       offset_q;
  logic [1:0]       kind_q;
  logic             done_q;
  logic [2:0]       verdict_q, verdict_d;
  logic [15:0]      payload_q, payload_d;
  logic [LEN_W-1:0] hdr;

  assign item_take_o = item_valid_i && (!valid_q || pop_i);

  always_comb begin
    verdict_d = VERDICT_OK;
    hdr       = HDR_DOM_BASE + LEN_W'(item_i.name_len);
    if (item_i.kind == KIND_V4) begin
      hdr = HDR_V4;
    end else if (item_i.kind == KIND_V6) begin
      hdr = HDR_V6;
    end
    if (item_i.eop) begin
      if (item_i.len < MIN_LEN) begin
        verdict_d = VERDICT_SHORT;
      end else if (item_i.rsv_bad) begin
        verdict_d = VERDICT_RSV_BAD;
      end else if (item_i.type_bad || item_i.kind == KIND_NONE) begin
        verdict_d = VERDICT_TYPE_BAD;
      end else if (item_i.kind == KIND_DOM) begin
        if (item_i.len < HDR_DOM_BASE) begin
          verdict_d = VERDICT_SHORT;
        end else if (item_i.name_len == 8'd0) begin
          verdict_d = VERDICT_ZERO_NAME;
        end else if (item_i.len < hdr) begin
          verdict_d = VERDICT_SHORT;
        end
      end else if (item_i.len < hdr) begin
        verdict_d = VERDICT_SHORT;
      end
    end
    payload_d = (item_i.eop && verdict_d == VERDICT_OK) ? 16'(item_i.len - hdr) : 16'd0;
  end

  always_ff @(posedge clk_i) begin
    if (item_take_o) begin
      byte_q    <= item_i.data;
      role_q    <= item_i.role;
      offset_q  <= item_i.offset;
      kind_q    <= item_i.kind;
      done_q    <= item_i.eop;
      verdict_q <= verdict_d;
      payload_q <= payload_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (item_take_o) begin
      valid_q <= 1'b1;
    end else if (pop_i) begin
      valid_q <= 1'b0;
    end
  end

  assign empty_o         = !valid_q;
  assign byte_out_o      = byte_q;
  assign byte_role_o     = role_q;
  assign field_offset_o  = offset_q;
  assign address_kind_o  = kind_q;
  assign packet_done_o   = done_q;
  assign verdict_o       = verdict_q;
  assign payload_bytes_o = payload_q;

`ifndef SYNTHESIS
  a_verdict_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !done_q) |-> (verdict_q == VERDICT_OK && payload_q == 16'd0))
    else $error("verdict or payload on a non-final byte");

  a_payload_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && verdict_q != VERDICT_OK) |-> (payload_q == 16'd0))
    else $error("payload length with a failing verdict");
`endif

endmodule

// ===== rtl/core/socks5_udp_header_parser.sv =====
// top level of the socks5 udp relay header parser
//
// input channel: one datagram byte per transfer on data_byte_i, with
// end_of_packet_i high on the final byte; a transfer happens at a clock
// edge with push high and full low
// result channel: one tagged byte per input byte, in order; the oldest
// result sits on the output ports while empty is low and is taken at an
// edge with pop high and empty low
// throughput: one byte per cycle sustained while pop stays high; the front
// end tags a byte in the cycle it arrives, the back end works out verdict
// and payload length from the queue head and holds it in the result register
// order: the transfer edge writes the queue, an edge with the result register
// free loads it from the queue, and empty drops right after that load
// reset: all header state clears, queue and result register are empty
// stall: while pop stays low the two-entry queue fills behind the result
// register, then full rises; nothing is lost or repeated
// datagrams longer than MAX_DATAGRAM_BYTES are counted as that length
module socks5_udp_header_parser #(
  parameter int MAX_DATAGRAM_BYTES = 65535
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_packet_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  byte_out_o,
  output logic [2:0]  byte_role_o,
  output logic [7:0]  field_offset_o,
  output logic [1:0]  address_kind_o,
  output logic        packet_done_o,
  output logic [2:0]  verdict_o,
  output logic [15:0] payload_bytes_o
);
  import suh_pkg::*;

  item_t front_item;
  item_t head_item;
  logic  in_xfer;
  logic  fifo_full;
  logic  fifo_empty;
  logic  head_take;

  // an input transfer goes straight into the queue
  assign in_xfer = push && !fifo_full;
  assign full    = fifo_full;

  suh_front #(
    .MAX_DATAGRAM_BYTES(MAX_DATAGRAM_BYTES)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (in_xfer),
    .data_byte_i    (data_byte_i),
    .end_of_packet_i(end_of_packet_i),
    .item_o         (front_item)
  );

  suh_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (in_xfer),
    .wdata_i(front_item),
    .pop_i  (head_take),
    .rdata_o(head_item),
    .full_o (fifo_full),
    .empty_o(fifo_empty)
  );

  // back end pulls the queue head whenever its result register frees up
  suh_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (head_item),
    .item_valid_i   (!fifo_empty),
    .item_take_o    (head_take),
    .pop_i          (pop),
    .empty_o        (empty),
    .byte_out_o     (byte_out_o),
    .byte_role_o    (byte_role_o),
    .field_offset_o (field_offset_o),
    .address_kind_o (address_kind_o),
    .packet_done_o  (packet_done_o),
    .verdict_o      (verdict_o),
    .payload_bytes_o(payload_bytes_o)
  );

endmodule

// ===== verif/tb.sv =====
// self-checking testbench for the socks5 udp header parser
`timescale 1ns / 1ps

module tb;
  import suh_pkg::*;

  localparam int MAX_BYTES   = 65535;
  localparam int HOLD_CYCLES = 200;
  localparam int RAND_BYTES  = 870;

  // one tagged byte as it leaves the block
  typedef struct packed {
    logic [7:0]  data;
    logic [2:0]  role;
    logic [7:0]  offset;
    logic [1:0]  kind;
    logic        done;
    logic [2:0]  verdict;
    logic [15:0] payload;
  } tag_rec_t;

  // header tracker plus the queue of tagged bytes still owed by the block
  class tag_scoreboard;
    int unsigned pos;
    logic [1:0]  kind;
    int unsigned name_len;
    bit          rsv_bad;
    bit          typ_bad;
    tag_rec_t    tag_q[$];
    int          errors;
    int          checked;
    int          verdicts[5];

    function new();
      clear_header();
      errors  = 0;
      checked = 0;
      foreach (verdicts[i]) verdicts[i] = 0;
    endfunction

    function void clear_header();
      pos      = 0;
      kind     = KIND_NONE;
      name_len = 0;
      rsv_bad  = 0;
      typ_bad  = 0;
    endfunction

    function void fixed_field(int unsigned p, int unsigned alen,
                              output logic [2:0] role, output logic [7:0] off);
      if (p < 4 + alen) begin
        role = ROLE_ADDR;
        off  = 8'(p - 4);
      end else if (p < 6 + alen) begin
        role = ROLE_PORT;
        off  = 8'(p - 4 - alen);
      end else begin
        role = ROLE_PAY;
        off  = 8'd0;
      end
    endfunction

    // work out the tag of one accepted byte and queue it
    function void note_byte(logic [7:0] b, logic e);
      tag_rec_t    t;
      int unsigned p;
      int unsigned plen;
      int unsigned hdr;
      p = (pos > MAX_BYTES - 1) ? MAX_BYTES - 1 : pos;
      t.data    = b;
      t.role    = ROLE_PAY;
      t.offset  = 8'd0;
      t.done    = e;
      t.verdict = VERDICT_OK;
      t.payload = 16'd0;
      if (p < 3) begin
        t.role = ROLE_RSV;
        if (b != 8'd0) rsv_bad = 1;
      end else if (p == 3) begin
        t.role = ROLE_TYPE;
        case (b)
          ATYP_V4:  kind = KIND_V4;
          ATYP_DOM: kind = KIND_DOM;
          ATYP_V6:  kind = KIND_V6;
          default: begin
            kind    = KIND_NONE;
            typ_bad = 1;
          end
        endcase
      end else if (kind == KIND_V4) begin
        fixed_field(p, 4, t.role, t.offset);
      end else if (kind == KIND_V6) begin
        fixed_field(p, 16, t.role, t.offset);
      end else if (kind == KIND_DOM) begin
        if (p == 4) begin
          t.role   = ROLE_LEN;
          name_len = b;
        end else if (p < 5 + name_len) begin
          t.role   = ROLE_ADDR;
          t.offset = 8'(p - 5);
        end else if (p < 7 + name_len) begin
          t.role   = ROLE_PORT;
          t.offset = 8'(p - 5 - name_len);
        end
      end
      t.kind = kind;
      if (e) begin
        plen = p + 1;
        hdr  = 0;
        if (plen < MIN_LEN) t.verdict = VERDICT_SHORT;
        else if (rsv_bad) t.verdict = VERDICT_RSV_BAD;
        else if (typ_bad || kind == KIND_NONE) t.verdict = VERDICT_TYPE_BAD;
        else if (kind == KIND_V4) begin
          hdr = HDR_V4;
          if (plen < hdr) t.verdict = VERDICT_SHORT;
        end else if (kind == KIND_V6) begin
          hdr = HDR_V6;
          if (plen < hdr) t.verdict = VERDICT_SHORT;
        end else begin
          hdr = HDR_DOM_BASE + name_len;
          if (plen < HDR_DOM_BASE) t.verdict = VERDICT_SHORT;
          else if (name_len == 0) t.verdict = VERDICT_ZERO_NAME;
          else if (plen < hdr) t.verdict = VERDICT_SHORT;
        end
        if (t.verdict == VERDICT_OK) t.payload = 16'(plen - hdr);
        clear_header();
      end else if (pos < MAX_BYTES) begin
        pos++;
      end
      tag_q.push_back(t);
    endfunction

    function void field_ok(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        if (errors <= 10)
          $display("mismatch on %s at result %0d: expected %0h, got %0h",
                   name, checked, want, got);
      end
    endfunction

    function void check_result(tag_rec_t got);
      tag_rec_t want;
      if (tag_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("result %0h with no byte outstanding", got);
        return;
      end
      want = tag_q.pop_front();
      field_ok("byte_out", want.data, got.data);
      field_ok("byte_role", want.role, got.role);
      field_ok("field_offset", want.offset, got.offset);
      field_ok("address_kind", want.kind, got.kind);
      field_ok("packet_done", want.done, got.done);
      field_ok("verdict", want.verdict, got.verdict);
      field_ok("payload_bytes", want.payload, got.payload);
      if (want.done && want.verdict <= VERDICT_ZERO_NAME) verdicts[want.verdict]++;
      checked++;
    endfunction

    function int pending();
      return tag_q.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni          = 1'b0;
  logic        push_i          = 1'b0;
  logic        pop_i           = 1'b0;
  logic [7:0]  data_byte_i     = 8'd0;
  logic        end_of_packet_i = 1'b0;
  logic        full;
  logic        empty;
  logic [7:0]  byte_out_o;
  logic [2:0]  byte_role_o;
  logic [7:0]  field_offset_o;
  logic [1:0]  address_kind_o;
  logic        packet_done_o;
  logic [2:0]  verdict_o;
  logic [15:0] payload_bytes_o;

  tag_scoreboard sb = new();

  // datagram being assembled for the input side
  logic [7:0] dgram[$];
  int         n_dgrams    = 0;
  int         n_bytes     = 0;
  int         full_cycles = 0;

  socks5_udp_header_parser #(
    .MAX_DATAGRAM_BYTES(MAX_BYTES)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push_i),
    .full           (full),
    .data_byte_i    (data_byte_i),
    .end_of_packet_i(end_of_packet_i),
    .empty          (empty),
    .pop            (pop_i),
    .byte_out_o     (byte_out_o),
    .byte_role_o    (byte_role_o),
    .field_offset_o (field_offset_o),
    .address_kind_o (address_kind_o),
    .packet_done_o  (packet_done_o),
    .verdict_o      (verdict_o),
    .payload_bytes_o(payload_bytes_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // count edges where the sender is pushed back by a full queue
  always @(posedge clk_i) begin
    if (push_i && full) full_cycles++;
  end

  // gap length: mostly none, often short, now and then long
  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // one byte transfer, then an optional idle gap on the input side
  task automatic send_byte(input logic [7:0] b, input logic e, input bit calm);
    int gap;
    push_i          <= 1'b1;
    data_byte_i     <= b;
    end_of_packet_i <= e;
    do @(posedge clk_i); while (full);
    sb.note_byte(b, e);
    gap = pick_gap(calm);
    if (gap > 0) begin
      push_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // some datagrams go through back to back with no input gaps at all
  task automatic send_dgram();
    bit calm;
    calm = ($urandom_range(0, 3) == 0);
    foreach (dgram[i]) send_byte(dgram[i], i == dgram.size() - 1, calm);
    n_dgrams++;
    n_bytes += dgram.size();
  endtask

  task automatic push_random(int count);
    repeat (count) dgram.push_back(8'($urandom));
  endtask

  // well-formed header of a random kind, random address, port and payload
  task automatic build_good();
    int pick;
    int nlen;
    dgram.delete();
    dgram = '{8'h00, 8'h00, 8'h00};
    pick = $urandom_range(0, 2);
    if (pick == 0) begin
      dgram.push_back(ATYP_V4);
      push_random(4);
    end else if (pick == 1) begin
      dgram.push_back(ATYP_V6);
      push_random(16);
    end else begin
      // long names are rare so the run stays short
      nlen = ($urandom_range(0, 19) == 0) ? 255 : $urandom_range(1, 24);
      dgram.push_back(ATYP_DOM);
      dgram.push_back(8'(nlen));
      push_random(nlen);
    end
    push_random(2);
    push_random($urandom_range(0, 24));
  endtask

  // damage a well-formed datagram in one of several ways
  task automatic break_dgram();
    logic [7:0] b;
    case ($urandom_range(0, 4))
      0: begin
        // cut anywhere, down to a single byte
        b = 8'($urandom_range(1, dgram.size() > 255 ? 255 : dgram.size()));
        while (dgram.size() > b) void'(dgram.pop_back());
      end
      1: dgram[$urandom_range(0, 2)] = 8'($urandom_range(1, 255));
      2: begin
        do b = 8'($urandom);
        while (b == ATYP_V4 || b == ATYP_DOM || b == ATYP_V6);
        dgram[3] = b;
      end
      3: begin
        // domain with a zero length byte and a random tail
        dgram = '{8'h00, 8'h00, 8'h00, ATYP_DOM, 8'h00};
        push_random($urandom_range(0, 8));
      end
      default: begin
        dgram.delete();
        push_random($urandom_range(1, 30));
      end
    endcase
  endtask

  // result side: random pop gaps, calm stretches and one long hold-off
  initial begin : result_side
    tag_rec_t got;
    int       gap;
    int       calm_left;
    bit       held;
    calm_left = 0;
    held      = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      // long hold-off so the queue fills and full rises against the sender
      if (!held && sb.checked >= 300) begin
        held = 1'b1;
        pop_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      if (calm_left > 0) calm_left--;
      else if ($urandom_range(0, 19) == 0) calm_left = $urandom_range(20, 60);
      gap = pick_gap(calm_left > 0);
      if (gap > 0) begin
        pop_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop_i <= 1'b1;
      do @(posedge clk_i); while (empty);
      got.data    = byte_out_o;
      got.role    = byte_role_o;
      got.offset  = field_offset_o;
      got.kind    = address_kind_o;
      got.done    = packet_done_o;
      got.verdict = verdict_o;
      got.payload = payload_bytes_o;
      sb.check_result(got);
    end
  end

  // input side: reset, directed datagrams, then random traffic
  initial begin : input_side
    int rand_bytes;
    rand_bytes = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // too short: one byte, three bytes, type byte only
    dgram = '{8'h00};
    send_dgram();
    dgram = '{8'h00, 8'h00, 8'h00};
    send_dgram();
    dgram = '{8'h00, 8'h00, 8'h00, ATYP_V4};
    send_dgram();
    // nonzero reserved byte ahead of a full ipv4 header
    dgram = '{8'hFF, 8'h00, 8'h00, ATYP_V4, 8'h0A, 8'h00, 8'h00, 8'h01, 8'h00, 8'h35};
    send_dgram();
    // unknown address type, trailing bytes become payload
    dgram = '{8'h00, 8'h00, 8'h00, 8'hFF, 8'hAA, 8'h55};
    send_dgram();
    // domain with zero length byte
    dgram = '{8'h00, 8'h00, 8'h00, ATYP_DOM, 8'h00, 8'h12, 8'h34, 8'hAB};
    send_dgram();
    // domain cut short before the minimum of seven bytes
    dgram = '{8'h00, 8'h00, 8'h00, ATYP_DOM, 8'h05, 8'h41};
    send_dgram();
    // ipv4 header with nothing after it
    dgram = '{8'h00, 8'h00, 8'h00, ATYP_V4, 8'hC0, 8'hA8, 8'h00, 8'h01, 8'h00, 8'h50};
    send_dgram();
    // ipv6 header with two payload bytes at the extremes
    dgram = '{8'h00, 8'h00, 8'h00, ATYP_V6};
    repeat (16) dgram.push_back(8'hFF);
    dgram.push_back(8'h01);
    dgram.push_back(8'hBB);
    dgram.push_back(8'hFF);
    dgram.push_back(8'h00);
    send_dgram();
    // shortest real domain plus one payload byte
    dgram = '{8'h00, 8'h00, 8'h00, ATYP_DOM, 8'h01, 8'h61, 8'h00, 8'h50, 8'h7F};
    send_dgram();

    // random traffic, mostly well formed
    while (rand_bytes < RAND_BYTES) begin
      build_good();
      if ($urandom_range(0, 99) >= 70) break_dgram();
      rand_bytes += dgram.size();
      send_dgram();
    end
    dgram.delete();
    push_i <= 1'b0;

    // drain, then keep idling so anything stray can still show up
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    $display("ran %0d datagrams, %0d bytes, %0d results checked",
             n_dgrams, n_bytes, sb.checked);
    $display("verdicts ok %0d short %0d reserved %0d type %0d zero-name %0d, %0d full stalls",
             sb.verdicts[VERDICT_OK], sb.verdicts[VERDICT_SHORT],
             sb.verdicts[VERDICT_RSV_BAD], sb.verdicts[VERDICT_TYPE_BAD],
             sb.verdicts[VERDICT_ZERO_NAME], full_cycles);
    if (sb.errors == 0) begin
      $display("[socks5_udp_header_parser] OK");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("[socks5_udp_header_parser] ERROR");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin : watchdog
    #40_000_000;
    $display("timeout with %0d results outstanding", sb.pending());
    $display("[socks5_udp_header_parser] ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/suh_pkg.sv
rtl/core/suh_front.sv
rtl/core/suh_fifo.sv
rtl/core/suh_back.sv
rtl/core/socks5_udp_header_parser.sv
verif/tb.sv
